// ----- rtl/srg_pkg.sv -----
// Shared types and constants for the stepper ramp generator.
// No dependencies; imported by every module of the block.
package srg_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_DECEL = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOW,
    ST_SPEED,
    ST_SQ,
    ST_RAMP,
    ST_STEP,
    ST_SSPD,
    ST_SSQ,
    ST_SDIV,
    ST_FINISH
  } seq_state_t;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_SOFT   = 3'd2;
  localparam logic [2:0] CMD_ESTOP  = 3'd3;
  localparam logic [2:0] CMD_SETPOS = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_BUSY    = 2'd2;

  localparam logic [1:0] REG_TIMER_FREQ = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd2;

  localparam int unsigned TimerFreqReset = 1000000;
  localparam int unsigned MinSpeedReset  = 10;
  localparam int unsigned MaxSpeedReset  = 5000;
  localparam int unsigned FastestReset   = TimerFreqReset / MaxSpeedReset;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

// ----- rtl/srg_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// 33-bit or 64-bit dividend, 32-bit divisor; zero divisor gives 32'hFFFF_FFFF with the upper half zero.
// Depends on srg_pkg.
module srg_div
  import srg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        long_mode,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dsr;
  logic        dz;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= long_mode ? 6'd63 : 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= long_mode ? dividend : {dividend[32:0], 31'd0};
      rem <= '0;
      dsr <= divisor;
      dz  <= (divisor == 32'd0);
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(trial - {1'b0, dsr});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign quotient = dz ? {32'd0, ALL_ONES} : quo;

endmodule

// ----- rtl/srg_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, 32 x 32 -> 64.
// Depends on srg_pkg.
module srg_mul
  import srg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] mcand_in,
  input  logic [31:0] mplier_in,
  output logic        done,
  output logic [63:0] product
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] mcand;
  logic [32:0] sum;

  assign sum = {1'b0, product[63:32]} + (product[0] ? {1'b0, mcand} : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= mcand_in;
      product <= {32'd0, mplier_in};
    end else if (busy) begin
      product <= {sum, product[31:1]};
    end
  end

endmodule

// ----- rtl/stepper_ramp_generator.sv -----
// Stepper ramp generator top level: sequencer, motion state, APB registers.
// Depends on srg_pkg, srg_div, srg_mul.
//
// One transaction in, one result out. Simple commands (set position, stops
// without a ramp, ticks outside a ramp) go straight to the finish state.
// A tick while accelerating runs one division and one while decelerating
// two; a start with a ramp runs two divisions, a multiplication and a
// division, a soft stop with a ramp a division, a multiplication and a
// 64-bit division. The bit-serial divider and multiplier run one at a time.
// The input is stalled while a transaction is in work; a finished result
// sits in the output register; while it stalls, the next one waits in ST_FINISH.
module stepper_ramp_generator
  import srg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] move_steps,
  input  logic [15:0]        speed_pps,
  input  logic [15:0]        accel_rate,
  input  logic [31:0]        first_period,
  input  logic signed [31:0] new_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               step_pulse,
  output logic               direction,
  output logic signed [31:0] position,
  output logic [31:0]        period,
  output logic [1:0]         motion_mode,
  output logic               move_done
);

  // configuration
  logic [26:0] tick_rate;
  logic [15:0] min_speed_pps;
  logic [15:0] speed_ceiling;
  logic        cfg_wr;

  // motion state
  mode_t       mode;
  logic [31:0] position_count;
  logic        move_direction;
  logic [31:0] steps_done;
  logic [31:0] steps_total;
  logic [31:0] decel_begin;
  logic [31:0] ramp_index;
  logic [31:0] step_period;
  logic [31:0] fastest_period;
  logic [15:0] move_accel;

  // latched transaction
  logic [2:0]  cmd_r;
  logic [31:0] steps_r;
  logic [15:0] speed_r;
  logic [15:0] accel_r;
  logic [31:0] c0_r;
  logic [31:0] newpos_r;

  // intermediate results
  logic [31:0] slow_r;
  logic [31:0] spd_r;
  logic [63:0] sq_r;
  logic [63:0] q_r;

  seq_state_t  state;
  seq_state_t  state_next;
  logic        launch;
  logic        accept;
  logic        out_free;

  logic        div_start;
  logic        div_long;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [63:0] div_q;
  logic        mul_start;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;

  logic [31:0] sd_inc;
  logic [31:0] ri_inc;
  logic [31:0] den;
  logic        start_bad;

  // next values
  mode_t       mode_next;
  logic [31:0] position_count_next;
  logic        move_direction_next;
  logic [31:0] steps_done_next;
  logic [31:0] steps_total_next;
  logic [31:0] decel_begin_next;
  logic [31:0] ramp_index_next;
  logic [31:0] step_period_next;
  logic [31:0] fastest_period_next;
  logic [15:0] move_accel_next;
  logic [1:0]  status_next;
  logic        pulse_next;
  logic        done_next;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate     <= 27'(TimerFreqReset);
      min_speed_pps <= 16'(MinSpeedReset);
      speed_ceiling <= 16'(MaxSpeedReset);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TIMER_FREQ: tick_rate     <= pwdata[26:0];
        REG_MIN_SPEED:  min_speed_pps <= pwdata[15:0];
        REG_MAX_SPEED:  speed_ceiling <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMER_FREQ: prdata = {5'd0, tick_rate};
      REG_MIN_SPEED:  prdata = {16'd0, min_speed_pps};
      REG_MAX_SPEED:  prdata = {16'd0, speed_ceiling};
      default:        prdata = 32'd0;
    endcase
  end

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  assign sd_inc = steps_done + 32'd1;
  assign ri_inc = ramp_index + 32'd1;
  assign den    = {ri_inc[29:0], 2'b01};

  assign start_bad = (move_steps == 32'sd0) || (speed_pps < min_speed_pps) ||
                     (speed_pps > speed_ceiling);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FINISH;
          if (command == CMD_TICK) begin
            if (mode != MODE_IDLE && sd_inc < steps_total) begin
              if (mode == MODE_ACCEL) state_next = ST_STEP;
              else if (mode == MODE_DECEL) state_next = ST_SLOW;
            end
          end else if (command == CMD_START) begin
            if (!start_bad && mode == MODE_IDLE) begin
              state_next = (accel_rate == 16'd0) ? ST_SPEED : ST_SLOW;
            end
          end else if (command == CMD_SOFT) begin
            if ((mode == MODE_ACCEL || mode == MODE_RUN) && move_accel != 16'd0) begin
              state_next = ST_SSPD;
            end
          end
        end
      end
      ST_SLOW:   if (div_done) state_next = (cmd_r == CMD_TICK) ? ST_STEP : ST_SPEED;
      ST_SPEED:  if (div_done) state_next = (accel_r == 16'd0) ? ST_FINISH : ST_SQ;
      ST_SQ:     if (mul_done) state_next = ST_RAMP;
      ST_RAMP:   if (div_done) state_next = ST_FINISH;
      ST_STEP:   if (div_done) state_next = ST_FINISH;
      ST_SSPD:   if (div_done) state_next = ST_SSQ;
      ST_SSQ:    if (mul_done) state_next = ST_SDIV;
      ST_SDIV:   if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state);
    end
  end

  // unit control
  always_comb begin
    div_start    = 1'b0;
    div_long     = 1'b0;
    div_dividend = {37'd0, tick_rate};
    div_divisor  = {16'd0, min_speed_pps};
    mul_start    = 1'b0;
    mul_a        = {16'd0, speed_r};
    mul_b        = {16'd0, speed_r};
    unique case (state)
      ST_SLOW:  div_start = launch;
      ST_SPEED: begin
        div_start   = launch;
        div_divisor = {16'd0, speed_r};
      end
      ST_SQ:    mul_start = launch;
      ST_RAMP: begin
        div_start    = launch;
        div_dividend = {31'd0, sq_r[32:0]};
        div_divisor  = {15'd0, accel_r, 1'b0};
      end
      ST_STEP: begin
        div_start    = launch;
        div_dividend = {31'd0, step_period, 1'b0};
        div_divisor  = den;
      end
      ST_SSPD: begin
        div_start   = launch;
        div_divisor = step_period;
      end
      ST_SSQ: begin
        mul_start = launch;
        mul_a     = spd_r;
        mul_b     = spd_r;
      end
      ST_SDIV: begin
        div_start    = launch;
        div_long     = 1'b1;
        div_dividend = sq_r;
        div_divisor  = {15'd0, move_accel, 1'b0};
      end
      default: ;
    endcase
  end

  srg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .long_mode (div_long),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q)
  );

  srg_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (mul_a),
    .mplier_in (mul_b),
    .done      (mul_done),
    .product   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= command;
      steps_r  <= $unsigned(move_steps);
      speed_r  <= speed_pps;
      accel_r  <= accel_rate;
      c0_r     <= first_period;
      newpos_r <= $unsigned(new_position);
    end
    if (div_done) begin
      unique case (state)
        ST_SLOW:          slow_r <= div_q[31:0];
        ST_SPEED, ST_SSPD: spd_r <= div_q[31:0];
        default:          q_r    <= div_q;
      endcase
    end
    if (mul_done) sq_r <= mul_p;
  end

  // motion update
  logic [31:0] mag;
  logic [31:0] sp_acc;
  logic [33:0] sp_dec;
  logic [31:0] c0_clamp;
  logic [31:0] dsteps;
  logic [32:0] total_sum;

  always_comb begin
    mode_next           = mode;
    position_count_next = position_count;
    move_direction_next = move_direction;
    steps_done_next     = steps_done;
    steps_total_next    = steps_total;
    decel_begin_next    = decel_begin;
    ramp_index_next     = ramp_index;
    step_period_next    = step_period;
    fastest_period_next = fastest_period;
    move_accel_next     = move_accel;
    status_next         = STS_OK;
    pulse_next          = 1'b0;
    done_next           = 1'b0;
    mag       = steps_r[31] ? 32'(32'd0 - steps_r) : steps_r;
    sp_acc    = step_period - q_r[31:0];
    sp_dec    = {2'b0, step_period} + {1'b0, q_r[32:0]};
    c0_clamp  = (c0_r > slow_r) ? slow_r : c0_r;
    dsteps    = (q_r[63:32] != 32'd0) ? ALL_ONES : q_r[31:0];
    if (dsteps == 32'd0) dsteps = 32'd1;
    total_sum = {1'b0, steps_done} + {1'b0, dsteps};

    unique case (cmd_r)
      CMD_TICK: begin
        if (mode != MODE_IDLE) begin
          pulse_next          = 1'b1;
          steps_done_next     = sd_inc;
          position_count_next = move_direction ? position_count - 32'd1
                                               : position_count + 32'd1;
          if (sd_inc >= steps_total) begin
            mode_next        = MODE_IDLE;
            step_period_next = 32'd0;
            done_next        = 1'b1;
          end else if (mode == MODE_ACCEL) begin
            ramp_index_next  = ri_inc;
            step_period_next = sp_acc;
            if (sp_acc <= fastest_period) begin
              step_period_next = fastest_period;
              mode_next        = MODE_RUN;
            end
            if (sd_inc >= decel_begin) begin
              mode_next       = MODE_DECEL;
              ramp_index_next = 32'd0;
            end
          end else if (mode == MODE_RUN) begin
            if (sd_inc >= decel_begin) begin
              mode_next       = MODE_DECEL;
              ramp_index_next = 32'd0;
            end
          end else begin
            ramp_index_next  = ri_inc;
            step_period_next = (sp_dec >= {2'b0, slow_r}) ? slow_r : sp_dec[31:0];
          end
        end
      end
      CMD_START: begin
        if (steps_r == 32'd0 || speed_r < min_speed_pps || speed_r > speed_ceiling) begin
          status_next = STS_INVALID;
        end else if (mode != MODE_IDLE) begin
          status_next = STS_BUSY;
        end else begin
          move_direction_next = steps_r[31];
          steps_total_next    = mag;
          steps_done_next     = 32'd0;
          move_accel_next     = accel_r;
          ramp_index_next     = 32'd0;
          if (accel_r == 16'd0) begin
            decel_begin_next = mag;
            step_period_next = spd_r;
            mode_next        = MODE_RUN;
          end else begin
            fastest_period_next = spd_r;
            if ({q_r[31:0], 1'b0} >= {1'b0, mag}) decel_begin_next = {1'b0, mag[31:1]};
            else decel_begin_next = mag - q_r[31:0];
            step_period_next = (c0_clamp < spd_r) ? spd_r : c0_clamp;
            mode_next        = MODE_ACCEL;
          end
        end
      end
      CMD_SOFT: begin
        if (mode == MODE_ACCEL || mode == MODE_RUN) begin
          if (move_accel == 16'd0) begin
            mode_next        = MODE_IDLE;
            step_period_next = 32'd0;
            done_next        = 1'b1;
          end else begin
            steps_total_next = total_sum[32] ? ALL_ONES : total_sum[31:0];
            decel_begin_next = steps_done;
            mode_next        = MODE_DECEL;
            ramp_index_next  = 32'd0;
          end
        end
      end
      CMD_ESTOP: begin
        mode_next        = MODE_IDLE;
        step_period_next = 32'd0;
      end
      CMD_SETPOS: position_count_next = newpos_r;
      default:    status_next = STS_INVALID;
    endcase
  end

  wire commit = (state == ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      position_count <= '0;
      move_direction <= 1'b0;
      steps_done     <= '0;
      steps_total    <= '0;
      decel_begin    <= '0;
      ramp_index     <= '0;
      step_period    <= '0;
      fastest_period <= 32'(FastestReset);
      move_accel     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (commit) begin
        mode           <= mode_next;
        position_count <= position_count_next;
        move_direction <= move_direction_next;
        steps_done     <= steps_done_next;
        steps_total    <= steps_total_next;
        decel_begin    <= decel_begin_next;
        ramp_index     <= ramp_index_next;
        step_period    <= step_period_next;
        fastest_period <= fastest_period_next;
        move_accel     <= move_accel_next;
        out_valid      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= status_next;
      step_pulse  <= pulse_next;
      direction   <= move_direction_next;
      position    <= $signed(position_count_next);
      period      <= step_period_next;
      motion_mode <= mode_next;
      move_done   <= done_next;
    end
  end

endmodule

// ----- rtl/srg_checker.sv -----
// Port-level checks for the stepper ramp generator, bound to the top level.
// Depends on srg_pkg and stepper_ramp_generator's port list.
module srg_checker
  import srg_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic               step_pulse,
  input logic signed [31:0] position,
  input logic [31:0]        period,
  input logic [1:0]         motion_mode,
  input logic               move_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(period))
    else $error("result changed while stalled");

  a_idle_period: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motion_mode != MODE_IDLE) || (period == 32'd0))
    else $error("idle with nonzero period");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> motion_mode == MODE_IDLE && status == STS_OK)
    else $error("move done but not idle");

  a_pulse_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_pulse |-> status == STS_OK)
    else $error("step pulse with error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while first in work");

endmodule

bind stepper_ramp_generator srg_checker u_srg_checker (.*);
